@@ rtl/ilpe_pkg.sv @@
// ----------------------------------------------------------------------------
// ilpe_pkg
// Shared types, command codes, packet constants and key table for the
// intensity level packet encoder.
// ----------------------------------------------------------------------------
package ilpe_pkg;

    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_SET       = 3'd1;
    localparam logic [2:0] CMD_HIT       = 3'd2;
    localparam logic [2:0] CMD_STOP      = 3'd3;
    localparam logic [2:0] CMD_LINK_RST  = 3'd4;

    localparam logic [1:0] REG_HOLD_TICKS  = 2'd0;
    localparam logic [1:0] REG_DECAY_STEP  = 2'd1;
    localparam logic [1:0] REG_HIT_GAIN    = 2'd2;
    localparam logic [1:0] REG_SHOCK_FREQ  = 2'd3;

    localparam logic [6:0] LEVEL_MAX   = 7'd100;
    localparam logic [7:0] LEVEL_NONE  = 8'd255;

    localparam logic [7:0] PKT_HEAD    = 8'h23;
    localparam logic [7:0] PKT_CMD     = 8'h5A;
    localparam logic [7:0] PKT_ONE     = 8'h01;
    localparam logic [7:0] OP_ELECTRIC = 8'h90;
    localparam logic [7:0] OP_VIBRATE  = 8'h31;
    localparam logic [3:0] PKT_LAST_IDX = 4'd11;

    localparam logic [7:0] KEY_TAB [4][12] = '{
        '{8'h00, 8'h18, 8'h98, 8'hF7, 8'hA5, 8'h3D, 8'h0D, 8'h29, 8'h25, 8'h50, 8'h44, 8'h46},
        '{8'h00, 8'h45, 8'h6E, 8'h6A, 8'h6F, 8'h78, 8'h20, 8'h53, 8'h2D, 8'h31, 8'h2E, 8'h37},
        '{8'h00, 8'h65, 8'h78, 8'h20, 8'h54, 8'h6F, 8'h79, 8'h73, 8'h0A, 8'h8E, 8'h9D, 8'hA3},
        '{8'h00, 8'hC5, 8'hD6, 8'hE7, 8'hF8, 8'h0A, 8'h32, 8'h20, 8'h6F, 8'h62, 8'h0D, 8'h0A}
    };

    typedef struct packed {
        logic [15:0] hold_ticks;
        logic [6:0]  decay_step;
        logic [6:0]  hit_gain;
        logic [7:0]  shock_frequency;
    } cfg_t;

    typedef struct packed {
        logic               upd_en;
        logic [2:0]         cmd;
        logic signed [15:0] value;
        logic               sent_en;
        logic [6:0]         sent_level;
    } lvl_ctrl_t;

    typedef struct packed {
        logic       step;
        logic       kind;
        logic [3:0] idx;
    } byte_ctrl_t;

endpackage

@@ rtl/ilpe_level.sv @@
// ----------------------------------------------------------------------------
// ilpe_level
// Level state: applies one command to level, hold countdown and last sent level.
// ----------------------------------------------------------------------------
module ilpe_level (
    input  logic                aclk,
    input  logic                aresetn,
    input  ilpe_pkg::cfg_t      cfg,
    input  ilpe_pkg::lvl_ctrl_t ctrl,
    output logic [6:0]          level_now,
    output logic [7:0]          level_sent
);

    logic [6:0]  level_reg, level_next;
    logic [15:0] hold_reg, hold_next;
    logic [7:0]  sent_reg, sent_next;

    logic [15:0] hold_dec;
    logic [6:0]  set_level;
    logic [14:0] dmg;
    logic [15:0] dmg_round;
    logic [11:0] units;
    logic [18:0] prod;
    logic [18:0] hit_sum;
    logic [6:0]  decayed;

    always_comb begin
        hold_dec = (hold_reg != 16'd0) ? hold_reg - 16'd1 : 16'd0;

        if (ctrl.value[15]) begin
            set_level = 7'd0;
        end else if (ctrl.value > 16'sd100) begin
            set_level = ilpe_pkg::LEVEL_MAX;
        end else begin
            set_level = ctrl.value[6:0];
        end

        dmg       = ctrl.value[15] ? 15'd0 : ctrl.value[14:0];
        dmg_round = {1'b0, dmg} + 16'd8;
        units     = (dmg_round[15:4] == 12'd0) ? 12'd1 : dmg_round[15:4];
        prod      = 19'(units) * 19'(cfg.hit_gain);
        hit_sum   = prod + 19'(level_reg);

        decayed = (level_reg > cfg.decay_step) ? level_reg - cfg.decay_step : 7'd0;
    end

    always_comb begin
        level_next = level_reg;
        hold_next  = hold_reg;
        sent_next  = sent_reg;
        if (ctrl.upd_en) begin
            case (ctrl.cmd)
                ilpe_pkg::CMD_TICK: begin
                    hold_next = hold_dec;
                    if (level_reg != 7'd0 && hold_dec == 16'd0) begin
                        level_next = decayed;
                    end
                end
                ilpe_pkg::CMD_SET: begin
                    level_next = set_level;
                    hold_next  = cfg.hold_ticks;
                end
                ilpe_pkg::CMD_HIT: begin
                    level_next = (hit_sum > 19'(ilpe_pkg::LEVEL_MAX)) ?
                                 ilpe_pkg::LEVEL_MAX : hit_sum[6:0];
                    hold_next  = cfg.hold_ticks;
                end
                ilpe_pkg::CMD_STOP: begin
                    level_next = 7'd0;
                    hold_next  = 16'd0;
                end
                ilpe_pkg::CMD_LINK_RST: begin
                    sent_next = ilpe_pkg::LEVEL_NONE;
                end
                default: begin
                end
            endcase
        end
        if (ctrl.sent_en) begin
            sent_next = {1'b0, ctrl.sent_level};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 7'd0;
            hold_reg  <= 16'd0;
            sent_reg  <= ilpe_pkg::LEVEL_NONE;
        end else begin
            level_reg <= level_next;
            hold_reg  <= hold_next;
            sent_reg  <= sent_next;
        end
    end

    assign level_now  = level_reg;
    assign level_sent = sent_reg;

endmodule

@@ rtl/ilpe_byte_unit.sv @@
// ----------------------------------------------------------------------------
// ilpe_byte_unit
// Byte-serial packet builder: plain byte select, running checksum and
// chained-key obfuscation, one byte per step.
// ----------------------------------------------------------------------------
module ilpe_byte_unit (
    input  logic                 aclk,
    input  ilpe_pkg::byte_ctrl_t ctrl,
    input  logic [6:0]           level,
    input  logic [7:0]           freq,
    input  logic [2:0]           shock,
    output logic [7:0]           data_byte
);

    logic [7:0] sum_reg, sum_next;
    logic [7:0] prev_reg;
    logic [7:0] sum_cur;
    logic [7:0] plain;
    logic [7:0] key;

    always_comb begin
        sum_cur = (ctrl.idx == 4'd0) ? 8'd0 : sum_reg;
        case (ctrl.idx)
            4'd0:  plain = ilpe_pkg::PKT_HEAD;
            4'd1:  plain = ilpe_pkg::PKT_CMD;
            4'd4:  plain = ilpe_pkg::PKT_ONE;
            4'd5:  plain = ctrl.kind ? ilpe_pkg::OP_VIBRATE : ilpe_pkg::OP_ELECTRIC;
            4'd6:  plain = ctrl.kind ? {1'b0, level} : freq;
            4'd7:  plain = ctrl.kind ? 8'd0 : {5'd0, shock};
            4'd11: plain = sum_reg;
            default: plain = 8'd0;
        endcase
        key = ilpe_pkg::KEY_TAB[prev_reg[1:0]][ctrl.idx];
        if (ctrl.idx == 4'd0) begin
            data_byte = plain;
        end else begin
            data_byte = ((key ^ ilpe_pkg::PKT_HEAD) ^ plain) + key;
        end
        sum_next = sum_cur + plain;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.step) begin
            sum_reg  <= sum_next;
            prev_reg <= data_byte;
        end
    end

endmodule

@@ rtl/intensity_level_packet_encoder.sv @@
// ----------------------------------------------------------------------------
// intensity_level_packet_encoder
// Command-driven intensity level with two obfuscated 12-byte packets
// (electric, then vibrate) sent whenever the level differs from the last sent level and the link is up.
//
//   channel  dir  handshake         payload
//   s_       in   s_tvalid/tready   tuser: cmd; tdata: value, link_ready
//   m_       out  m_tvalid/tready   tuser: packet_kind; tdata: byte, index,
//                                   level; tlast: final byte of the run
//   cfg_     in   cfg_valid/ready   cfg_index, cfg_data; always ready
//
// An item passes through accept, level update and send decision; a send adds
// 24 output transactions, one byte per cycle unless m_tready low stalls the output,
// from the byte unit, whose key chain depends on the previous output byte.
// aresetn (synchronous) restores register defaults, level 0, no level sent.
// m_tready low freezes the byte sequence; the last byte may wait in the
// output register while the next input transaction is accepted.
// ----------------------------------------------------------------------------
module intensity_level_packet_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] value, [16] link_ready
    input  logic [2:0]  s_tuser,   // [2:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [11:8] byte_index, [18:12] sent_level
    output logic [0:0]  m_tuser,   // [0] packet_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_CHK  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]  state_reg, state_next;
    ilpe_pkg::cfg_t cfg_reg;

    logic [2:0]  cmd_reg;
    logic [15:0] value_reg;
    logic        link_reg;

    logic [6:0]  lv_reg;
    logic [7:0]  freq_reg;
    logic [2:0]  shock_reg;
    logic        kind_reg, kind_next;
    logic [3:0]  idx_reg, idx_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic        m_tlast_reg;

    logic [6:0]  level_now;
    logic [7:0]  level_sent;
    logic [7:0]  data_byte;
    logic        s_accept;
    logic        send;
    logic        load;
    logic        run_end;
    logic [2:0]  shock_calc;

    ilpe_pkg::lvl_ctrl_t  lvl_ctrl;
    ilpe_pkg::byte_ctrl_t byte_ctrl;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign send = (state_reg == ST_CHK) && link_reg &&
                  (cmd_reg inside {[ilpe_pkg::CMD_TICK:ilpe_pkg::CMD_STOP]}) &&
                  ({1'b0, level_now} != level_sent);
    assign load    = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign run_end = kind_reg && (idx_reg == ilpe_pkg::PKT_LAST_IDX);

    assign shock_calc = 3'(level_now > 7'd0)  + 3'(level_now > 7'd16) +
                        3'(level_now > 7'd33) + 3'(level_now > 7'd50) +
                        3'(level_now > 7'd66) + 3'(level_now > 7'd83);

    always_comb begin
        lvl_ctrl.upd_en     = (state_reg == ST_UPD);
        lvl_ctrl.cmd        = cmd_reg;
        lvl_ctrl.value      = value_reg;
        lvl_ctrl.sent_en    = send;
        lvl_ctrl.sent_level = level_now;
        byte_ctrl.step      = load;
        byte_ctrl.kind      = kind_reg;
        byte_ctrl.idx       = idx_reg;
    end

    ilpe_level u_level (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .ctrl       (lvl_ctrl),
        .level_now  (level_now),
        .level_sent (level_sent)
    );

    ilpe_byte_unit u_byte (
        .aclk      (aclk),
        .ctrl      (byte_ctrl),
        .level     (lv_reg),
        .freq      (freq_reg),
        .shock     (shock_reg),
        .data_byte (data_byte)
    );

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                state_next = ST_CHK;
            end
            ST_CHK: begin
                kind_next  = 1'b0;
                idx_next   = 4'd0;
                state_next = send ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (load) begin
                    m_tvalid_next = 1'b1;
                    if (idx_reg == ilpe_pkg::PKT_LAST_IDX) begin
                        idx_next  = 4'd0;
                        kind_next = 1'b1;
                        if (kind_reg) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg               <= ST_IDLE;
            m_tvalid_reg            <= 1'b0;
            kind_reg                <= 1'b0;
            idx_reg                 <= 4'd0;
            cfg_reg.hold_ticks      <= 16'd140;
            cfg_reg.decay_step      <= 7'd1;
            cfg_reg.hit_gain        <= 7'd10;
            cfg_reg.shock_frequency <= 8'd4;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            kind_reg     <= kind_next;
            idx_reg      <= idx_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ilpe_pkg::REG_HOLD_TICKS: cfg_reg.hold_ticks      <= cfg_data;
                    ilpe_pkg::REG_DECAY_STEP: cfg_reg.decay_step      <= cfg_data[6:0];
                    ilpe_pkg::REG_HIT_GAIN:   cfg_reg.hit_gain        <= cfg_data[6:0];
                    ilpe_pkg::REG_SHOCK_FREQ: cfg_reg.shock_frequency <= cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg   <= s_tuser;
            value_reg <= s_tdata[15:0];
            link_reg  <= s_tdata[16];
        end
        if (state_reg == ST_CHK) begin
            lv_reg    <= level_now;
            freq_reg  <= (level_now == 7'd0) ? 8'd0 : cfg_reg.shock_frequency;
            shock_reg <= shock_calc;
        end
        if (load) begin
            m_tdata_reg <= {5'd0, lv_reg, idx_reg, data_byte};
            m_tuser_reg <= kind_reg;
            m_tlast_reg <= run_end;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input accepted while busy");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        level_now <= ilpe_pkg::LEVEL_MAX)
        else $error("level out of range");

    a_sent_recorded: assert property (@(posedge aclk) disable iff (!aresetn)
        send |=> (level_sent == {1'b0, lv_reg}))
        else $error("sent level not recorded");

    a_last_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && run_end) |=> (m_tlast && m_tuser[0] && (m_tdata[11:8] == ilpe_pkg::PKT_LAST_IDX)))
        else $error("last flag on wrong byte");

    a_emit_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !load)
        else $error("output register overwritten");

endmodule
